// ----- rtl/set_assoc_transposition_table_defines.svh -----
// Assertion macros used by the transposition table controller.
`ifndef SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH
`define SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with a fixed message.
`define SATT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("satt: assertion failed");
// Clocked assertion with a caller message.
`define SATT_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
`else
`define SATT_ASSERT(lbl, clk, rstn, prop)
`define SATT_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

// ----- rtl/satt_pkg.sv -----
// Types, constants and helpers shared by the transposition table modules.
package satt_pkg;

  // Table geometry
  localparam int unsigned CLUSTERS_DEF = 1024;
  localparam int unsigned SATT_WAYS    = 4;
  localparam int unsigned WAY_W        = 2;

  // Remainder unit: key bits folded in per step
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned DIGIT_W      = 16;
  localparam int unsigned DIGITS       = KEY_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W  = $clog2(DIGITS);

  // Replacement scoring
  localparam logic [10:0] VICTIM_STALE = 11'd1000;
  localparam logic [10:0] VICTIM_BASE  = 11'd255;

  // Configuration defaults
  localparam logic [14:0] MATE_THR_RST = 15'd31000;
  localparam logic [7:0]  CUR_GEN_RST  = 8'd0;

  typedef enum logic [0:0] {
    CFG_MATE_THR = 1'b0,
    CFG_CUR_GEN  = 1'b1
  } satt_cfg_e;

  typedef enum logic [0:0] {
    OP_PROBE = 1'b0,
    OP_STORE = 1'b1
  } satt_op_e;

  typedef struct packed {
    satt_op_e           opcode;
    logic [63:0]        key;
    logic [7:0]         ply;
    logic signed [7:0]  store_depth;
    logic signed [15:0] score_in;
    logic [1:0]         bound_flag;
    logic [15:0]        packed_move;
  } satt_req_t;

  typedef struct packed {
    logic               found;
    logic [1:0]         way;
    logic signed [15:0] score_out;
    logic signed [7:0]  depth_out;
    logic [1:0]         flag_out;
    logic [15:0]        move_out;
    logic [7:0]         generation_out;
  } satt_rsp_t;

  // One stored entry and one set of four
  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
    logic signed [7:0]  depth;
    logic [1:0]         flag;
    logic [15:0]        move;
    logic [7:0]         gen;
  } satt_entry_t;

  typedef satt_entry_t [SATT_WAYS-1:0] satt_row_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic mod_step;
    logic rd_en;
    logic commit;
  } satt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } satt_sts_t;

  function automatic bit is_pow2(int unsigned n);
    return (n & (n - 1)) == 0;
  endfunction

  function automatic int unsigned idx_width(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- rtl/satt_dpath.sv -----
// Datapath: request and config registers, set index, set memory, hit and victim logic.
module satt_dpath #(
  parameter int unsigned CLUSTERS = satt_pkg::CLUSTERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  satt_pkg::satt_cmd_t cmd_i,
  output satt_pkg::satt_sts_t sts_o,
  input  satt_pkg::satt_req_t req_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [14:0]         cfg_data_i,
  output satt_pkg::satt_rsp_t rsp_o
);
  import satt_pkg::*;

  localparam int unsigned IDX_W = idx_width(CLUSTERS);

  // Mate score shift; to_tbl moves it away from zero by ply, else toward zero
  function automatic logic [15:0] mate_adj(logic signed [15:0] s, logic [7:0] ply,
                                           logic [14:0] thr, logic to_tbl);
    logic signed [16:0] s17;
    logic signed [16:0] thr17;
    logic signed [16:0] ply17;
    logic signed [16:0] r17;
    s17   = {s[15], s};
    thr17 = {2'b00, thr};
    ply17 = {9'b0, ply};
    if (s17 > thr17) begin
      r17 = to_tbl ? (s17 + ply17) : (s17 - ply17);
    end else if (s17 < -thr17) begin
      r17 = to_tbl ? (s17 - ply17) : (s17 + ply17);
    end else begin
      r17 = s17;
    end
    return r17[15:0];
  endfunction

  satt_req_t          req_q;
  logic [14:0]        mate_thr_q;
  logic [7:0]         cur_gen_q;
  logic [IDX_W-1:0]   clr_cnt_q;
  logic [IDX_W-1:0]   set_idx;
  satt_row_t          mem_q [CLUSTERS];
  satt_row_t          rd_row_q;
  satt_row_t          wr_row;
  satt_row_t          wr_data;
  logic [IDX_W-1:0]   wr_addr;
  logic               mem_we;
  satt_rsp_t          rsp_q;
  satt_rsp_t          rsp_d;
  logic [SATT_WAYS-1:0] hit;
  logic               any_hit;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   vic_way;
  logic [WAY_W-1:0]   tgt_way;
  logic [10:0]        vic [SATT_WAYS];
  logic [10:0]        vic_best;
  satt_entry_t        new_ent;
  satt_entry_t        hit_ent;

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_thr_q <= MATE_THR_RST;
      cur_gen_q  <= CUR_GEN_RST;
    end else if (cfg_we_i) begin
      unique case (satt_cfg_e'(cfg_idx_i))
        CFG_MATE_THR: mate_thr_q <= cfg_data_i;
        CFG_CUR_GEN:  cur_gen_q  <= cfg_data_i[7:0];
        default:      mate_thr_q <= mate_thr_q;
      endcase
    end
  end

  // Clearing pass row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= IDX_W'(clr_cnt_q + 1'b1);
    end
  end
  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(CLUSTERS - 1));

  // Set index: key mod CLUSTERS
  if (CLUSTERS == 1) begin : g_one_set
    assign set_idx       = '0;
    assign sts_o.mod_last = 1'b1;
  end else if (is_pow2(CLUSTERS)) begin : g_pow2
    assign set_idx       = req_q.key[IDX_W-1:0];
    assign sts_o.mod_last = 1'b1;
  end else begin : g_rem
    localparam int unsigned     X_W     = IDX_W + DIGIT_W;
    localparam int unsigned     MU_W    = DIGIT_W + 1;
    localparam logic [IDX_W:0]  MODULUS = (IDX_W + 1)'(CLUSTERS);
    localparam logic [63:0]     MU_FULL = (64'd1 << X_W) / 64'(CLUSTERS);
    localparam logic [MU_W-1:0] MU      = MU_FULL[MU_W-1:0];
    logic [IDX_W-1:0]       rem_q;
    logic [IDX_W-1:0]       rem_d;
    logic [X_W-1:0]         x_q;
    logic [X_W-1:0]         x_d;
    logic [DIGIT_W-1:0]     quo_q;
    logic [DIGIT_W-1:0]     quo_d;
    logic [X_W+MU_W-1:0]    prod;
    logic [X_W-1:0]         qm;
    logic [X_W-1:0]         diff;
    logic [IDX_W:0]         part;
    logic [DIGIT_CNT_W-1:0] dig_q;
    logic                   ph_q;
    logic [DIGIT_W-1:0]     digit;

    assign digit = req_q.key[{dig_q, 4'b0000} +: DIGIT_W];

    // First half of a step: shift the next digit in, estimate the quotient
    // with the reciprocal; the estimate is low by at most one
    assign x_d   = {rem_q, digit};
    assign prod  = {{MU_W{1'b0}}, x_d} * {{X_W{1'b0}}, MU};
    assign quo_d = prod[X_W +: DIGIT_W];

    // Second half: subtract quotient times modulus, then one correction
    assign qm    = {{IDX_W{1'b0}}, quo_q} * {{DIGIT_W{1'b0}}, MODULUS[IDX_W-1:0]};
    assign diff  = x_q - qm;
    assign part  = diff[IDX_W:0];
    assign rem_d = (part >= MODULUS) ? IDX_W'(part - MODULUS) : part[IDX_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
        x_q   <= '0;
        quo_q <= '0;
        dig_q <= '0;
        ph_q  <= 1'b0;
      end else if (cmd_i.load_in) begin
        rem_q <= '0;
        dig_q <= DIGIT_CNT_W'(DIGITS - 1);
        ph_q  <= 1'b0;
      end else if (cmd_i.mod_step) begin
        if (!ph_q) begin
          x_q   <= x_d;
          quo_q <= quo_d;
          ph_q  <= 1'b1;
        end else begin
          rem_q <= rem_d;
          dig_q <= DIGIT_CNT_W'(dig_q - 1'b1);
          ph_q  <= 1'b0;
        end
      end
    end

    assign set_idx        = rem_q;
    assign sts_o.mod_last = ph_q && (dig_q == '0);
  end

  // Set memory, one row of four ways per address
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_row_q <= mem_q[set_idx];
    end
  end

  // Hit detection, first matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < SATT_WAYS; w++) begin
      hit[w] = (rd_row_q[w].key == req_q.key);
    end
    for (int w = SATT_WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    any_hit = |hit;
    hit_ent = rd_row_q[hit_way];
  end

  // Victim choice: stale bonus plus shallow-depth bonus, first max wins
  always_comb begin
    for (int w = 0; w < SATT_WAYS; w++) begin
      vic[w] = ((rd_row_q[w].gen != cur_gen_q) ? VICTIM_STALE : 11'd0)
             + VICTIM_BASE - {{3{rd_row_q[w].depth[7]}}, rd_row_q[w].depth};
    end
    vic_best = vic[0];
    vic_way  = '0;
    for (int w = 1; w < SATT_WAYS; w++) begin
      if (vic[w] > vic_best) begin
        vic_best = vic[w];
        vic_way  = WAY_W'(w);
      end
    end
    tgt_way = any_hit ? hit_way : vic_way;
  end

  // Entry written by a store
  always_comb begin
    new_ent.key   = req_q.key;
    new_ent.score = mate_adj(req_q.score_in, req_q.ply, mate_thr_q, 1'b1);
    new_ent.depth = req_q.store_depth;
    new_ent.flag  = req_q.bound_flag;
    new_ent.move  = req_q.packed_move;
    new_ent.gen   = cur_gen_q;
    wr_row          = rd_row_q;
    wr_row[tgt_way] = new_ent;
  end

  // Memory write: zero rows while clearing, else store write-back
  always_comb begin
    if (cmd_i.clr_step) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      mem_we  = cmd_i.commit && (req_q.opcode == OP_STORE);
      wr_addr = set_idx;
      wr_data = wr_row;
    end
  end

  // Response
  always_comb begin
    rsp_d = '0;
    if (req_q.opcode == OP_STORE) begin
      rsp_d.way = tgt_way;
    end else if (any_hit) begin
      rsp_d.found          = 1'b1;
      rsp_d.way            = hit_way;
      rsp_d.score_out      = mate_adj(hit_ent.score, req_q.ply, mate_thr_q, 1'b0);
      rsp_d.depth_out      = hit_ent.depth;
      rsp_d.flag_out       = hit_ent.flag;
      rsp_d.move_out       = hit_ent.move;
      rsp_d.generation_out = hit_ent.gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- rtl/satt_ctrl.sv -----
// Controller: clearing pass, request sequencing and output valid.
`include "set_assoc_transposition_table_defines.svh"

module satt_ctrl #(
  parameter int unsigned CLUSTERS = satt_pkg::CLUSTERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output satt_pkg::satt_cmd_t cmd_o,
  input  satt_pkg::satt_sts_t sts_i
);
  import satt_pkg::*;

  localparam bit NEED_MOD = (CLUSTERS > 1) && !is_pow2(CLUSTERS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EVAL  = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  ctrl_state_e start_st;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        commit;
  logic        accept;

  assign start_st = NEED_MOD ? ST_MOD : ST_READ;

  // Result goes out when the output register is free or drains this cycle
  assign commit     = (state_q == ST_EVAL) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load_in  = accept;
    cmd_o.commit   = commit;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = start_st;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (commit) begin
          state_d = accept ? start_st : ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `SATT_ASSERT(a_commit_sets_valid, clk_i, rst_ni, cmd_o.commit |=> out_valid_q)
  `SATT_ASSERT_MSG(a_no_overwrite, clk_i, rst_ni, cmd_o.commit |-> (!out_valid_q || !out_stall_i), "satt: pending result overwritten")
  `SATT_ASSERT(a_read_then_eval, clk_i, rst_ni, cmd_o.rd_en |=> (state_q == ST_EVAL))
  `SATT_ASSERT_MSG(a_accept_starts, clk_i, rst_ni, accept |=> ((state_q == ST_MOD) || (state_q == ST_READ)), "satt: accepted request not started")

endmodule

// ----- rtl/set_assoc_transposition_table.sv -----
// Top level of the 4-way set-associative transposition table.
// 4-way set-associative transposition table, CLUSTERS sets of four 114-bit
// entries in a single-port row memory (one set read or written per cycle).
// After reset the block runs a clearing pass that zeroes every set;
// in_stall_o stays high during it, configuration writes are taken as usual.
// With CLUSTERS a power of two a request first reads its set, then compares
// the four keys, picks the hit or victim way, writes the set back on a store
// and loads the result register once the output register is free or drains.
// Otherwise the set index comes first from a remainder unit that folds in 16
// key bits per step with a reciprocal multiply. The next request is accepted
// in the cycle the current result is loaded, and while an earlier result
// still waits on out_stall_i. Write configuration only while no request is
// in flight.
module set_assoc_transposition_table #(
  parameter int unsigned CLUSTERS = satt_pkg::CLUSTERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  satt_pkg::satt_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output satt_pkg::satt_rsp_t out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [14:0]         cfg_data_i
);
  import satt_pkg::*;

  satt_cmd_t cmd;
  satt_sts_t sts;

  satt_ctrl #(
    .CLUSTERS (CLUSTERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  satt_dpath #(
    .CLUSTERS (CLUSTERS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (out_rsp_o)
  );

endmodule
